### rtl/pic_pkg.sv
package pic_pkg;

    // field widths of one input word and one result word
    localparam int KIND_W    = 2;
    localparam int OFS_W     = 22;
    localparam int DATA_W    = 32;
    localparam int CLAIM_W   = 5;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

    // register map
    localparam logic [OFS_W-1:0] OFS_PRIO_LAST = 22'h00007c;
    localparam logic [OFS_W-1:0] OFS_PENDING   = 22'h001000;
    localparam logic [OFS_W-1:0] OFS_ENABLE    = 22'h002080;
    localparam logic [OFS_W-1:0] OFS_THRESHOLD = 22'h201000;
    localparam logic [OFS_W-1:0] OFS_CLAIM     = 22'h201004;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic exec_read;
        logic exec_write;
        logic update_start;
        logic scan_step;
        logic finish;
        logic load_out;
    } pic_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              scan_last;
        logic              out_ready;
    } pic_status_t;

endpackage

### rtl/pic_ctrl.sv
module pic_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pic_pkg::pic_status_t  status,
    output pic_pkg::pic_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DECODE   = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_SCAN_END = 3'd3;
    localparam logic [2:0] ST_FINAL    = 3'd4;
    localparam logic [2:0] ST_RESULT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.kind)
                    pic_pkg::KIND_READ:
                    begin
                        cmd.exec_read = 1'b1;
                        state_next    = ST_RESULT;
                    end
                    pic_pkg::KIND_WRITE:
                    begin
                        cmd.exec_write = 1'b1;
                        state_next     = ST_RESULT;
                    end
                    pic_pkg::KIND_UPDATE:
                    begin
                        cmd.update_start = 1'b1;
                        state_next       = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                cmd.finish = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/pic_dp.sv
module pic_dp
#(
    parameter int NUM_SOURCES = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pic_pkg::pic_cmd_t            cmd,
    output pic_pkg::pic_status_t         status,
    input  logic [pic_pkg::KIND_W-1:0]   kind,
    input  logic [pic_pkg::OFS_W-1:0]    offset,
    input  logic [pic_pkg::DATA_W-1:0]   write_data,
    input  logic [pic_pkg::DATA_W-1:0]   ext_requests,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pic_pkg::DATA_W-1:0]   read_data,
    output logic                         irq_out
);

    localparam int         IDX_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam logic [5:0] SRC_CNT = 6'(NUM_SOURCES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SOURCES - 1);

    // captured item
    logic [pic_pkg::KIND_W-1:0] kind_reg;
    logic [pic_pkg::OFS_W-1:0]  offset_reg;
    logic [pic_pkg::DATA_W-1:0] write_data_reg;
    logic [NUM_SOURCES-1:0]     ext_reg;

    // register file
    logic [pic_pkg::DATA_W-1:0] prio_mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]     prio_vld_reg;
    logic [pic_pkg::DATA_W-1:0] prio_rd_reg;
    logic [NUM_SOURCES-1:0]     pending_reg;
    logic [NUM_SOURCES-1:0]     pending_next;
    logic [NUM_SOURCES-1:0]     enable_reg;
    logic [pic_pkg::DATA_W-1:0] threshold_reg;
    logic [pic_pkg::CLAIM_W-1:0] claim_id_reg;
    logic                       irq_flag_reg;

    // scan state
    logic [IDX_W-1:0]           scan_idx_reg;
    logic [IDX_W-1:0]           cmp_idx_reg;
    logic                       cmp_en_reg;
    logic [pic_pkg::DATA_W-1:0] best_prio_reg;
    logic [IDX_W-1:0]           best_id_reg;
    logic [NUM_SOURCES-1:0]     live;

    // result word
    logic                       out_valid_reg;
    logic [pic_pkg::DATA_W-1:0] read_data_reg;
    logic                       irq_out_reg;
    logic [pic_pkg::DATA_W-1:0] rdata_next;

    // address decode
    logic [4:0]       word_idx;
    logic             prio_sel;
    logic             idx_ok;
    logic [IDX_W-1:0] idx;
    logic [4:0]       clr_idx5;
    logic             clr_ok;
    logic [IDX_W-1:0] clr_idx;
    logic             mem_we;
    logic             mem_rd_en;
    logic             rd_ok;
    logic [IDX_W-1:0] mem_rd_addr;

    assign word_idx    = offset_reg[6:2];
    assign prio_sel    = (offset_reg <= pic_pkg::OFS_PRIO_LAST);
    assign idx_ok      = ({1'b0, word_idx} < SRC_CNT);
    assign idx         = word_idx[IDX_W-1:0];
    assign clr_idx5    = write_data_reg[4:0];
    assign clr_ok      = ({1'b0, clr_idx5} < SRC_CNT);
    assign clr_idx     = clr_idx5[IDX_W-1:0];
    assign mem_we      = cmd.exec_write && prio_sel && idx_ok;
    assign mem_rd_en   = cmd.exec_read || cmd.scan_step;
    assign rd_ok       = cmd.scan_step || idx_ok;
    assign mem_rd_addr = cmd.scan_step ? scan_idx_reg : idx;
    assign live        = pending_reg & enable_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg       <= kind;
            offset_reg     <= offset;
            write_data_reg <= write_data;
            ext_reg        <= ext_requests[NUM_SOURCES-1:0];
        end
    end

    // priority memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prio_mem[idx] <= write_data_reg;
        end
        if (mem_rd_en)
        begin
            prio_rd_reg <= (rd_ok && prio_vld_reg[mem_rd_addr]) ? prio_mem[mem_rd_addr] : '0;
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_vld_reg <= '0;
        end
        else if (mem_we)
        begin
            prio_vld_reg[idx] <= 1'b1;
        end
    end

    // pending: or in requests on update, clear on completion
    always_comb
    begin
        pending_next = pending_reg;
        if (cmd.update_start)
        begin
            pending_next = pending_reg | ext_reg;
        end
        else if (cmd.exec_write && (offset_reg == pic_pkg::OFS_CLAIM) && clr_ok)
        begin
            pending_next[clr_idx] = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            enable_reg    <= '0;
            threshold_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (cmd.exec_write && (offset_reg == pic_pkg::OFS_ENABLE))
            begin
                enable_reg <= write_data_reg[NUM_SOURCES-1:0];
            end
            if (cmd.exec_write && (offset_reg == pic_pkg::OFS_THRESHOLD))
            begin
                threshold_reg <= write_data_reg;
            end
        end
    end

    // scan counter and compare stage, which works on the memory read of the previous cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_idx_reg   <= '0;
            cmp_en_reg    <= 1'b0;
            best_prio_reg <= '0;
            best_id_reg   <= '0;
        end
        else
        begin
            cmp_en_reg  <= cmd.scan_step;
            cmp_idx_reg <= scan_idx_reg;
            if (cmd.update_start)
            begin
                scan_idx_reg  <= '0;
                best_prio_reg <= '0;
                best_id_reg   <= '0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (cmp_en_reg && live[cmp_idx_reg] && (prio_rd_reg > best_prio_reg))
                begin
                    best_prio_reg <= prio_rd_reg;
                    best_id_reg   <= cmp_idx_reg;
                end
            end
        end
    end

    // claim and interrupt flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claim_id_reg <= '0;
            irq_flag_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            claim_id_reg <= pic_pkg::CLAIM_W'(best_id_reg);
            irq_flag_reg <= (best_prio_reg > threshold_reg);
        end
    end

    // read mux
    always_comb
    begin
        rdata_next = '0;
        if (kind_reg == pic_pkg::KIND_READ)
        begin
            if (prio_sel)
            begin
                rdata_next = prio_rd_reg;
            end
            else
            begin
                case (offset_reg)
                    pic_pkg::OFS_PENDING:   rdata_next = pic_pkg::DATA_W'(pending_reg);
                    pic_pkg::OFS_ENABLE:    rdata_next = pic_pkg::DATA_W'(enable_reg);
                    pic_pkg::OFS_THRESHOLD: rdata_next = threshold_reg;
                    pic_pkg::OFS_CLAIM:     rdata_next = pic_pkg::DATA_W'(claim_id_reg);
                    default:                rdata_next = '0;
                endcase
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_data_reg <= rdata_next;
            irq_out_reg   <= irq_flag_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = read_data_reg;
    assign irq_out          = irq_out_reg;
    assign status.kind      = kind_reg;
    assign status.scan_last = (scan_idx_reg == IDX_LAST);
    assign status.out_ready = !out_valid_reg || !out_stall;

endmodule

### rtl/platform_interrupt_controller.sv
// sequence: reads, writes and unused kinds go from decode to the result state, which waits for the output;
//   an update tick goes from decode through the priority scan, scan end and final states to the result state
// flow: a new item is taken only once the last one has loaded its result word; an update is
//   held by the priority scan that reads one stored priority per cycle from the memory port
// reset: asynchronous, active low; control state, output valid, pending, enables, threshold,
//   claim and flag clear at once, priority entries read as zero until written, no clearing pass
module platform_interrupt_controller
#(
    parameter int NUM_SOURCES = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pic_pkg::KIND_W-1:0]  kind,
    input  logic [pic_pkg::OFS_W-1:0]   offset,
    input  logic [pic_pkg::DATA_W-1:0]  write_data,
    input  logic [pic_pkg::DATA_W-1:0]  ext_requests,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pic_pkg::DATA_W-1:0]  read_data,
    output logic                        irq_out
);

    pic_pkg::pic_cmd_t    cmd;
    pic_pkg::pic_status_t status;

    // sequencer
    pic_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // registers, priority memory and scan
    pic_dp #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .offset       (offset),
        .write_data   (write_data),
        .ext_requests (ext_requests),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .irq_out      (irq_out)
    );

endmodule

### rtl/pic_chk.sv
module pic_chk
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [pic_pkg::KIND_W-1:0]  kind,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [pic_pkg::DATA_W-1:0]  read_data,
    input logic                        irq_out
);

    logic [pic_pkg::KIND_W-1:0] kind_reg;

    // kind of the last accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= pic_pkg::KIND_READ;
        end
        else if (in_valid && !in_stall)
        begin
            kind_reg <= kind;
        end
    end

    // one word in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a word is still in flight");

    // block frees up only when its result is shown
    a_result_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("input released without a result word");

    // only reads return data
    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) && (kind_reg != pic_pkg::KIND_READ) |-> (read_data == '0))
        else $error("nonzero read data for a word that is not a read");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(irq_out))
        else $error("result word changed while stalled");

endmodule

bind platform_interrupt_controller pic_chk u_pic_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .irq_out   (irq_out)
);
